@@ hdl/dual_channel_window_min_max_avg_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dual channel window min/max/average unit
// Shared clocked assertion forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_WINDOW_MIN_MAX_AVG_UNIT_DEFINES_SVH
`define DUAL_CHANNEL_WINDOW_MIN_MAX_AVG_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DCWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DCWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dcwm_pkg.sv @@
// ----------------------------------------------------------------------------
// dcwm_pkg
// Types and fixed constants of the dual channel window min/max/average unit.
// ----------------------------------------------------------------------------
package dcwm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int ACC_BITS    = 16;
  localparam int VREF_BITS   = 14;
  localparam int VOLT_BITS   = 14;
  localparam int PROD_BITS   = ACC_BITS + VREF_BITS;
  localparam int WLOG_BITS   = 3;
  localparam int MODE_BITS   = 2;
  localparam int REL_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 14;

  // Operating modes
  localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_AVG = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VREF   = 2'd2;

  // Relation codes
  localparam logic [REL_BITS-1:0] REL_EQ = 2'd0;
  localparam logic [REL_BITS-1:0] REL_GT = 2'd1;
  localparam logic [REL_BITS-1:0] REL_LT = 2'd2;

  localparam logic [VREF_BITS-1:0] VREF_RESET = 14'd3300;
  localparam logic [ACC_BITS-1:0]  ACC_FULL   = 16'hFFFF;
  localparam logic [VOLT_BITS-1:0] VOLT_MAX   = 14'd16383;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
  } sample_t;

  typedef struct packed {
    logic [VOLT_BITS-1:0] volts_a;
    logic [VOLT_BITS-1:0] volts_b;
    logic [REL_BITS-1:0]  relation;
  } result_t;

  // Control shared by both lanes
  typedef struct packed {
    logic                 step;      // sample accepted
    logic                 capture;   // window ends on this sample
    logic                 arm;       // reload accumulator
    logic                 arm_full;  // reload to all ones (minimum mode)
    logic [MODE_BITS-1:0] mode;
  } lane_ctrl_t;

endpackage

@@ hdl/dcwm_lane.sv @@
// ----------------------------------------------------------------------------
// dcwm_lane
// One channel: running min/max/sum accumulator and millivolt scaling product.
// ----------------------------------------------------------------------------
module dcwm_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  dcwm_pkg::lane_ctrl_t                ctl,
  input  logic [dcwm_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic [dcwm_pkg::VREF_BITS-1:0]      vref,
  output logic [dcwm_pkg::PROD_BITS-1:0]      prod
);

  logic [dcwm_pkg::ACC_BITS-1:0] acc;
  logic [dcwm_pkg::ACC_BITS-1:0] acc_next;
  logic [dcwm_pkg::ACC_BITS-1:0] sample_ext;

  assign sample_ext = dcwm_pkg::ACC_BITS'(sample);

  // Fold the new sample into the running value
  always_comb begin
    case (ctl.mode)
      dcwm_pkg::MODE_MIN: acc_next = (sample_ext < acc) ? sample_ext : acc;
      dcwm_pkg::MODE_MAX: acc_next = (sample_ext > acc) ? sample_ext : acc;
      dcwm_pkg::MODE_AVG: acc_next = acc + sample_ext;
      default:            acc_next = acc;
    endcase
  end

  // Hold the accumulator; re-arm wins over the update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= dcwm_pkg::ACC_FULL;
    end else if (ctl.arm) begin
      acc <= ctl.arm_full ? dcwm_pkg::ACC_FULL : '0;
    end else if (ctl.step) begin
      acc <= acc_next;
    end
  end

  // Scale the closing window value by the reference
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      prod <= dcwm_pkg::PROD_BITS'(acc_next) * dcwm_pkg::PROD_BITS'(vref);
    end
  end

endmodule

@@ hdl/dcwm_merge.sv @@
// ----------------------------------------------------------------------------
// dcwm_merge
// Shift and saturate both lane products, compare them, hold the result.
// ----------------------------------------------------------------------------
`include "dual_channel_window_min_max_avg_unit_defines.svh"

module dcwm_merge #(
  parameter int SHIFT_W = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             prod_valid,
  output logic                             prod_ready,
  input  logic [dcwm_pkg::PROD_BITS-1:0]   prod_a,
  input  logic [dcwm_pkg::PROD_BITS-1:0]   prod_b,
  input  logic [SHIFT_W-1:0]               shift,
  output logic                             result_valid,
  input  logic                             result_stall,
  output dcwm_pkg::result_t                result
);

  logic [dcwm_pkg::PROD_BITS-1:0] shifted_a;
  logic [dcwm_pkg::PROD_BITS-1:0] shifted_b;
  logic [dcwm_pkg::VOLT_BITS-1:0] volt_a;
  logic [dcwm_pkg::VOLT_BITS-1:0] volt_b;
  logic [dcwm_pkg::REL_BITS-1:0]  rel;
  logic                           load;

  // Drop the fraction bits and clamp to the output range
  always_comb begin
    shifted_a = prod_a >> shift;
    shifted_b = prod_b >> shift;
    volt_a = (shifted_a > dcwm_pkg::PROD_BITS'(dcwm_pkg::VOLT_MAX)) ?
             dcwm_pkg::VOLT_MAX : shifted_a[dcwm_pkg::VOLT_BITS-1:0];
    volt_b = (shifted_b > dcwm_pkg::PROD_BITS'(dcwm_pkg::VOLT_MAX)) ?
             dcwm_pkg::VOLT_MAX : shifted_b[dcwm_pkg::VOLT_BITS-1:0];
    if (volt_a > volt_b) begin
      rel = dcwm_pkg::REL_GT;
    end else if (volt_a < volt_b) begin
      rel = dcwm_pkg::REL_LT;
    end else begin
      rel = dcwm_pkg::REL_EQ;
    end
  end

  assign prod_ready = !result_valid || !result_stall;
  assign load       = prod_valid && prod_ready;

  // Output register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (prod_ready) begin
      result_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.volts_a  <= volt_a;
      result.volts_b  <= volt_b;
      result.relation <= rel;
    end
  end

  `DCWM_ASSERT_NOW(a_rel_eq, result_valid && result.relation == dcwm_pkg::REL_EQ, result.volts_a == result.volts_b, "equal flag with different values")
  `DCWM_ASSERT_NOW(a_rel_gt, result_valid && result.relation == dcwm_pkg::REL_GT, result.volts_a > result.volts_b, "greater flag disagrees with values")
  `DCWM_ASSERT_NOW(a_rel_lt, result_valid && result.relation == dcwm_pkg::REL_LT, result.volts_a < result.volts_b, "less flag disagrees with values")
  `DCWM_ASSERT_NEXT(a_drain, result_valid && !result_stall && !prod_valid, !result_valid, "request delivered twice")

endmodule

@@ hdl/dual_channel_window_min_max_avg_unit.sv @@
// ----------------------------------------------------------------------------
// dual_channel_window_min_max_avg_unit
// Two-channel windowed min/max/average decimator with millivolt scaling.
// ----------------------------------------------------------------------------
// Throughput: one sample pair per cycle while sample_stall is low; each lane does one compare or add.
// Result path: the sample that closes the window is scaled in the lane multiply
//   register, then passes the merge shift/clamp/compare register.
// Reset: mode minimum, window of one sample, vref 3300 mV, accumulators all
//   ones, pipeline empty.
module dual_channel_window_min_max_avg_unit #(
  parameter int WINDOW_CHOICES = 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dcwm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dcwm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  dcwm_pkg::sample_t                    sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output dcwm_pkg::result_t                    result
);

  localparam int CNT_W   = (WINDOW_CHOICES > 1) ? WINDOW_CHOICES - 1 : 1;
  localparam int SHIFT_W = $clog2(dcwm_pkg::SAMPLE_BITS + WINDOW_CHOICES);
  localparam logic [dcwm_pkg::WLOG_BITS-1:0] K_MAX =
    dcwm_pkg::WLOG_BITS'(WINDOW_CHOICES - 1);

  logic [dcwm_pkg::MODE_BITS-1:0] mode;
  logic [dcwm_pkg::MODE_BITS-1:0] mode_next;
  logic [dcwm_pkg::WLOG_BITS-1:0] wlog;
  logic [dcwm_pkg::WLOG_BITS-1:0] wlog_next;
  logic [dcwm_pkg::VREF_BITS-1:0] vref;
  logic [dcwm_pkg::WLOG_BITS-1:0] k_next;
  logic [dcwm_pkg::WLOG_BITS-1:0] k_cur;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               reload;
  logic                           cfg_hit;
  logic                           accept;
  logic                           win_end;
  logic                           prod_valid;
  logic                           prod_ready;
  logic [SHIFT_W-1:0]             shift;
  logic [dcwm_pkg::PROD_BITS-1:0] prod_a;
  logic [dcwm_pkg::PROD_BITS-1:0] prod_b;
  dcwm_pkg::lane_ctrl_t           ctl;

  // Decode the register write
  always_comb begin
    mode_next = mode;
    wlog_next = wlog;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        dcwm_pkg::REG_MODE: begin
          mode_next = cfg_data[dcwm_pkg::MODE_BITS-1:0];
          cfg_hit   = 1'b1;
        end
        dcwm_pkg::REG_WINDOW: begin
          wlog_next = cfg_data[dcwm_pkg::WLOG_BITS-1:0];
          cfg_hit   = 1'b1;
        end
        dcwm_pkg::REG_VREF: begin
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= dcwm_pkg::MODE_MIN;
      wlog <= '0;
      vref <= dcwm_pkg::VREF_RESET;
    end else begin
      mode <= mode_next;
      wlog <= wlog_next;
      if (cfg_we && cfg_index == dcwm_pkg::REG_VREF) begin
        vref <= cfg_data[dcwm_pkg::VREF_BITS-1:0];
      end
    end
  end

  // Clamp the window exponent to the supported range
  assign k_next = (wlog_next > K_MAX) ? K_MAX : wlog_next;
  assign k_cur  = (wlog > K_MAX) ? K_MAX : wlog;
  assign reload = CNT_W'((32'd1 << k_next) - 32'd1);

  assign sample_stall = prod_valid && !prod_ready;
  assign accept       = sample_valid && !sample_stall;
  assign win_end      = (count == '0);

  // Count down the window; re-arm on window end or register write
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_hit || (accept && win_end)) begin
      count <= reload;
    end else if (accept) begin
      count <= count - CNT_W'(1);
    end
  end

  always_comb begin
    ctl.step     = accept;
    ctl.capture  = accept && win_end;
    ctl.arm      = cfg_hit || (accept && win_end);
    ctl.arm_full = (mode_next == dcwm_pkg::MODE_MIN);
    ctl.mode     = mode;
  end

  // Track the product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctl.capture) begin
      prod_valid <= 1'b1;
    end else if (prod_ready) begin
      prod_valid <= 1'b0;
    end
  end

  assign shift = (mode == dcwm_pkg::MODE_AVG) ?
                 SHIFT_W'(dcwm_pkg::SAMPLE_BITS) + SHIFT_W'(k_cur) :
                 SHIFT_W'(dcwm_pkg::SAMPLE_BITS);

  dcwm_lane u_lane_a (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (sample.sample_a),
    .vref   (vref),
    .prod   (prod_a)
  );

  dcwm_lane u_lane_b (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (sample.sample_b),
    .vref   (vref),
    .prod   (prod_b)
  );

  dcwm_merge #(
    .SHIFT_W (SHIFT_W)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .prod_valid   (prod_valid),
    .prod_ready   (prod_ready),
    .prod_a       (prod_a),
    .prod_b       (prod_b),
    .shift        (shift),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual channel window min/max/average unit.
// Sample pairs go in through the valid/stall channel and a tracker class
// models the windowed min, max and average with millivolt scaling. Each
// result that leaves the block is compared field by field with the oldest
// window reading waiting in the tracker. Directed corners come first, then
// random phases: the block is drained, every register is rewritten, and a
// run of whole windows, sometimes with a trailing partial window, follows.
// Both sides idle in random bursts until the final stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WINDOW_CHOICES = 5;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_PAIRS   = 800;
  localparam int CALM_AT        = 730;
  localparam int LIMIT          = 200000;

  // Codes the package leaves unnamed
  localparam logic [dcwm_pkg::MODE_BITS-1:0]    MODE_SPARE = 2'd3;
  localparam logic [dcwm_pkg::CFG_IDX_BITS-1:0] REG_SPARE  = 2'd3;

  logic                               clk          = 1'b0;
  logic                               rst          = 1'b1;
  logic                               cfg_we       = 1'b0;
  logic [dcwm_pkg::CFG_IDX_BITS-1:0]  cfg_index    = '0;
  logic [dcwm_pkg::CFG_DATA_BITS-1:0] cfg_data     = '0;
  logic                               sample_valid = 1'b0;
  logic                               sample_stall;
  dcwm_pkg::sample_t                  sample       = '0;
  logic                               result_valid;
  logic                               result_stall = 1'b0;
  dcwm_pkg::result_t                  result;

  bit          calm        = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent        = 0;

  dual_channel_window_min_max_avg_unit #(
    .WINDOW_CHOICES(WINDOW_CHOICES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Window model: accumulators, countdown and the readings still owed
  class window_result_tracker;
    logic [dcwm_pkg::MODE_BITS-1:0] mode;
    logic [dcwm_pkg::WLOG_BITS-1:0] wlog;
    logic [dcwm_pkg::VREF_BITS-1:0] vref;
    logic [dcwm_pkg::ACC_BITS-1:0]  acc_a;
    logic [dcwm_pkg::ACC_BITS-1:0]  acc_b;
    int unsigned                    left;
    dcwm_pkg::result_t              due_readings[$];
    int unsigned                    errors;
    int unsigned                    pairs;
    int unsigned                    windows;
    int unsigned                    writes;

    function new();
      mode    = dcwm_pkg::MODE_MIN;
      wlog    = '0;
      vref    = dcwm_pkg::VREF_RESET;
      errors  = 0;
      pairs   = 0;
      windows = 0;
      writes  = 0;
      restart();
    endfunction

    // Clamp the exponent to the supported window sizes
    function int unsigned span_log2();
      return (wlog > WINDOW_CHOICES - 1) ? WINDOW_CHOICES - 1 : int'(wlog);
    endfunction

    function void restart();
      acc_a = (mode == dcwm_pkg::MODE_MIN) ? dcwm_pkg::ACC_FULL : '0;
      acc_b = acc_a;
      left  = 1 << span_log2();
    endfunction

    // Out-of-range indexes are dropped without re-arming
    function void write_reg(logic [dcwm_pkg::CFG_IDX_BITS-1:0]  idx,
                            logic [dcwm_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        dcwm_pkg::REG_MODE: begin
          mode = data[dcwm_pkg::MODE_BITS-1:0];
        end
        dcwm_pkg::REG_WINDOW: begin
          wlog = data[dcwm_pkg::WLOG_BITS-1:0];
        end
        dcwm_pkg::REG_VREF: begin
          vref = data[dcwm_pkg::VREF_BITS-1:0];
        end
        default: begin
          return;
        end
      endcase
      writes++;
      restart();
    endfunction

    function logic [dcwm_pkg::VOLT_BITS-1:0] to_millivolts(
      logic [dcwm_pkg::ACC_BITS-1:0] acc, int unsigned shift);
      logic [dcwm_pkg::PROD_BITS-1:0] prod;
      prod = dcwm_pkg::PROD_BITS'(acc) * dcwm_pkg::PROD_BITS'(vref);
      prod = prod >> shift;
      return (prod > dcwm_pkg::PROD_BITS'(dcwm_pkg::VOLT_MAX)) ?
             dcwm_pkg::VOLT_MAX : prod[dcwm_pkg::VOLT_BITS-1:0];
    endfunction

    // Fold one pair in; close the window on its last sample
    function void note_sample(dcwm_pkg::sample_t s);
      dcwm_pkg::result_t             r;
      int unsigned                   shift;
      logic [dcwm_pkg::ACC_BITS-1:0] ext_a;
      logic [dcwm_pkg::ACC_BITS-1:0] ext_b;
      pairs++;
      ext_a = dcwm_pkg::ACC_BITS'(s.sample_a);
      ext_b = dcwm_pkg::ACC_BITS'(s.sample_b);
      case (mode)
        dcwm_pkg::MODE_MIN: begin
          if (ext_a < acc_a) acc_a = ext_a;
          if (ext_b < acc_b) acc_b = ext_b;
        end
        dcwm_pkg::MODE_MAX: begin
          if (ext_a > acc_a) acc_a = ext_a;
          if (ext_b > acc_b) acc_b = ext_b;
        end
        dcwm_pkg::MODE_AVG: begin
          acc_a = acc_a + ext_a;
          acc_b = acc_b + ext_b;
        end
        default: begin
        end
      endcase
      if (left > 1) begin
        left--;
        return;
      end
      shift = dcwm_pkg::SAMPLE_BITS + ((mode == dcwm_pkg::MODE_AVG) ? span_log2() : 0);
      r.volts_a  = to_millivolts(acc_a, shift);
      r.volts_b  = to_millivolts(acc_b, shift);
      r.relation = (r.volts_a > r.volts_b) ? dcwm_pkg::REL_GT :
                   (r.volts_a < r.volts_b) ? dcwm_pkg::REL_LT : dcwm_pkg::REL_EQ;
      due_readings.push_back(r);
      restart();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(dcwm_pkg::result_t got);
      dcwm_pkg::result_t want;
      if (due_readings.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d rel %0d",
                         got.volts_a, got.volts_b, got.relation));
        return;
      end
      want = due_readings.pop_front();
      windows++;
      if (got.volts_a !== want.volts_a)
        report($sformatf("volts_a got %0d want %0d", got.volts_a, want.volts_a));
      if (got.volts_b !== want.volts_b)
        report($sformatf("volts_b got %0d want %0d", got.volts_b, want.volts_b));
      if (got.relation !== want.relation)
        report($sformatf("relation got %0d want %0d", got.relation, want.relation));
    endtask
  endclass

  window_result_tracker tracker = new();

  initial begin
    forever #5 clk = ~clk;
  end

  // Watch both channels and the register port at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.write_reg(cfg_index, cfg_data);
      if (sample_valid && !sample_stall) tracker.note_sample(sample);
      if (result_valid === 1'b1 && !result_stall) tracker.check_result(result);
    end
  end

  // Stall the result side in random bursts until the final stretch
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= (stall_left > 1);
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(1, 10);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles", LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one request, optionally after a random gap, and hold until taken
  task automatic send_sample(dcwm_pkg::sample_t s, bit no_gap);
    if (!no_gap && !calm && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall !== 1'b0) @(posedge clk);
    sent++;
  endtask

  task automatic send_pair(int unsigned a, int unsigned b);
    dcwm_pkg::sample_t s;
    s.sample_a = a[dcwm_pkg::SAMPLE_BITS-1:0];
    s.sample_b = b[dcwm_pkg::SAMPLE_BITS-1:0];
    send_sample(s, 1'b0);
  endtask

  // Drop valid, let the last request reach the tracker, wait for every
  // owed reading, then let the pipeline empty
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic drive_reg(logic [dcwm_pkg::CFG_IDX_BITS-1:0] idx, int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[dcwm_pkg::CFG_DATA_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic configure(logic [dcwm_pkg::MODE_BITS-1:0] m, int unsigned wl,
                           int unsigned vr);
    settle();
    drive_reg(dcwm_pkg::REG_MODE, 32'(m));
    drive_reg(dcwm_pkg::REG_WINDOW, wl);
    drive_reg(dcwm_pkg::REG_VREF, vr);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [dcwm_pkg::SAMPLE_BITS-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return dcwm_pkg::SAMPLE_BITS'(
                        $urandom_range(0, (1 << dcwm_pkg::SAMPLE_BITS) - 1));
    endcase
  endfunction

  initial begin
    logic [dcwm_pkg::MODE_BITS-1:0] m;
    int unsigned                    wl;
    int unsigned                    vr;
    int unsigned                    len;
    int unsigned                    count;
    int unsigned                    target;
    bit                             quiet;
    dcwm_pkg::sample_t              s;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: minimum over one sample, relation in all three senses
    send_pair(0, 4095);
    send_pair(4095, 0);
    send_pair(2048, 2048);

    // Maximum with full-scale reference
    configure(dcwm_pkg::MODE_MAX, 1, 16383);
    send_pair(4095, 4095);
    send_pair(0, 0);

    // Average over two samples
    configure(dcwm_pkg::MODE_AVG, 1, 9999);
    send_pair(4095, 1);
    send_pair(4095, 2);

    // Unused mode: accumulators hold their re-armed value
    configure(MODE_SPARE, 0, 1234);
    send_pair(3000, 17);

    // Oversized window exponent clamps to sixteen samples
    configure(dcwm_pkg::MODE_MIN, 7, 5000);
    for (int i = 0; i < 16; i++) send_pair(4000 - i * 130, 100 + i * 250);

    // Write to a missing register must not re-arm a half-filled window
    configure(dcwm_pkg::MODE_MIN, 1, 9999);
    send_pair(100, 200);
    settle();
    drive_reg(REG_SPARE, 14'h2AAA);
    cfg_we <= 1'b0;
    send_pair(50, 300);

    // Random phases of whole windows with random content, some with a trailing partial window
    target = sent + RANDOM_PAIRS;
    while (sent < target) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4:      m = dcwm_pkg::MODE_MIN;
        5, 6, 7, 8, 9:      m = dcwm_pkg::MODE_MAX;
        10, 11, 12, 13, 14: m = dcwm_pkg::MODE_AVG;
        default:            m = MODE_SPARE;
      endcase
      wl = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 7);
      case ($urandom_range(0, 5))
        0: vr = 0;
        1: vr = 16383;
        2: vr = 9999;
        default: vr = $urandom_range(0, 16383);
      endcase
      configure(m, wl, vr);
      len   = 1 << ((wl > WINDOW_CHOICES - 1) ? WINDOW_CHOICES - 1 : wl);
      count = len * ((len == 16) ? $urandom_range(1, 3) : $urandom_range(1, 8));
      if (len > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, len - 1);
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
        if (sent >= target - (RANDOM_PAIRS - CALM_AT)) calm = 1'b1;
        // Occasionally hold off until every owed reading is out
        if (!calm && $urandom_range(0, 39) == 0) settle();
        s.sample_a = pick_level();
        s.sample_b = pick_level();
        send_sample(s, quiet);
      end
    end

    calm = 1'b1;
    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d sample pairs, %0d windows, %0d register writes",
             tracker.pairs, tracker.windows, tracker.writes);
    $display("mismatches: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
